/* rtl/ops_pkg.sv */
`default_nettype none
package ops_pkg;
  localparam int MAX_OBJECTS = 1024;
  localparam int ADDR_W      = 64;
  localparam int IDX_W       = $clog2(MAX_OBJECTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int STRIDE_W    = 25;
  localparam int SPAN_W      = STRIDE_W + CNT_W;
  localparam int PROD_W      = STRIDE_W + IDX_W;
  localparam int ROW_BITS    = 32;
  localparam int BIT_W       = $clog2(ROW_BITS);
  localparam int ROWS        = MAX_OBJECTS / ROW_BITS;
  localparam int ROW_W       = $clog2(ROWS);

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_FREE   = 3'd1;
  localparam logic [2:0] OP_TEST   = 3'd2;
  localparam logic [2:0] OP_FIRST  = 3'd3;
  localparam logic [2:0] OP_NEXT   = 3'd4;
  localparam logic [2:0] OP_REINIT = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DBL_ALOC = 3'd3;
  localparam logic [2:0] ST_DBL_FREE = 3'd4;
  localparam logic [2:0] ST_BAD_ADDR = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_STRIDE = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;
  localparam logic [1:0] REG_TRACK  = 2'd3;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [ADDR_W-1:0] object_address;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] result_address;
    logic [CNT_W-1:0]  result_index;
    logic              in_use;
  } res_t;
endpackage
`default_nettype wire

/* rtl/object_pool_free_stack.sv */
// Alloc/free/test/next go from accept to result beat through the 10-step
//   shift-subtract address-to-index divider, the stack read for alloc and, with
//   tracking on, one bitmap RAM read.
// First/next scans read the bitmap one 32-bit row at a time; reinit writes one
//   stack entry per cycle for the object count capped at 1024, then returns its
//   beat. One command at a time; busy is low again in the result cycle. Results
//   appear for one cycle on done; the receiver cannot stall.
// Reset (sync, rst high) clears stack top and bitmap row-valid flags, and puts
//   config to its defaults (stride 1, everything else zero).
`default_nettype none
module object_pool_free_stack (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire ops_pkg::cmd_t         cmd,
  output logic                       busy,
  output logic                       done,
  output ops_pkg::res_t              result,
  input  wire logic                  wr_en,
  input  wire logic [1:0]            wr_index,
  input  wire logic [ops_pkg::ADDR_W-1:0] wr_data
);
  import ops_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_CV_MUL, S_CV_CHK, S_CV_DIV, S_CV_END, S_MAP_RD,
    S_SC_RD, S_SC_CHK, S_IA_MUL, S_IA_ADD, S_RI_LOOP
  } state_t;

  state_t state;

  logic [ADDR_W-1:0]   pool_base;
  logic [STRIDE_W-1:0] object_stride;
  logic [CNT_W-1:0]    object_count;
  logic                tracking_enable;

  logic [CNT_W-1:0]    n_eff;
  logic [CNT_W-1:0]    stack_top;
  logic [ROWS-1:0]     row_valid;
  logic [2:0]          op;
  logic                full;
  logic [ADDR_W-1:0]   cv_addr;
  logic [ADDR_W-1:0]   off;
  logic                below;
  logic [SPAN_W-1:0]   span;
  logic [SPAN_W-1:0]   rem;
  logic [IDX_W-1:0]    q;
  logic [3:0]          bitn;
  logic                cv_ok;
  logic [CNT_W-1:0]    scan_pos;
  logic [PROD_W-1:0]   prod;
  logic [CNT_W-1:0]    ri_i;
  logic [ADDR_W-1:0]   ri_addr;

  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr;
  logic [ADDR_W-1:0]   stk_wdata;
  logic [IDX_W-1:0]    stk_raddr;
  logic [ADDR_W-1:0]   stk_rdata;
  logic                map_we;
  logic [ROW_W-1:0]    map_raddr;
  logic [ROW_BITS-1:0] map_wdata;
  logic [ROW_BITS-1:0] map_rdata;

  logic [ROW_BITS-1:0] obj_row;
  logic [ROW_BITS-1:0] scan_row;
  logic                obj_bit;
  logic [SPAN_W-1:0]   trial;
  logic                sc_found;
  logic [BIT_W-1:0]    sc_bit;
  logic [CNT_W-1:0]    idx_out;
  logic                off_big;

  assign n_eff = (object_count > CNT_W'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS) : object_count;
  assign busy  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base       <= '0;
      object_stride   <= STRIDE_W'(1);
      object_count    <= '0;
      tracking_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BASE:   pool_base       <= wr_data;
        REG_STRIDE: object_stride   <= wr_data[STRIDE_W-1:0];
        REG_COUNT:  object_count    <= wr_data[CNT_W-1:0];
        REG_TRACK:  tracking_enable <= wr_data[0];
        default:    ;
      endcase
    end
  end

  ops_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_OBJECTS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  ops_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_map (
    .clk(clk), .we(map_we), .waddr(q[IDX_W-1:BIT_W]), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  // rows never written since reset/reinit read as all clear
  assign obj_row  = row_valid[q[IDX_W-1:BIT_W]] ? map_rdata : '0;
  assign scan_row = row_valid[scan_pos[IDX_W-1:BIT_W]] ? map_rdata : '0;
  assign obj_bit  = obj_row[q[BIT_W-1:0]];
  assign trial    = SPAN_W'({object_stride, 9'b0} >> (4'd9 - bitn));
  assign idx_out  = cv_ok ? {1'b0, q} : n_eff;
  assign off_big  = (off[ADDR_W-1:SPAN_W] != '0) || (off[SPAN_W-1:0] >= span);

  always_comb begin
    stk_raddr = stack_top[IDX_W-1:0] - IDX_W'(1);
    stk_we    = 1'b0;
    stk_waddr = stack_top[IDX_W-1:0];
    stk_wdata = cv_addr;
    if (state == S_RI_LOOP) begin
      stk_we    = (ri_i < n_eff);
      stk_waddr = ri_i[IDX_W-1:0];
      stk_wdata = ri_addr;
    end else if (state == S_CV_END && op == OP_FREE && !full && !tracking_enable) begin
      stk_we = 1'b1;
    end else if (state == S_MAP_RD && op == OP_FREE && obj_bit) begin
      stk_we = 1'b1;
    end
  end

  always_comb begin
    map_raddr = (state == S_SC_RD) ? scan_pos[IDX_W-1:BIT_W] : q[IDX_W-1:BIT_W];
    map_wdata = obj_row ^ (ROW_BITS'(1) << q[BIT_W-1:0]);
    map_we    = (state == S_MAP_RD) &&
                ((op == OP_ALLOC && !obj_bit) || (op == OP_FREE && obj_bit));
  end

  // lowest marked object at or after scan_pos within this row and below count
  always_comb begin
    sc_found = 1'b0;
    sc_bit   = '0;
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (scan_row[j] && (BIT_W'(j) >= scan_pos[BIT_W-1:0]) &&
          ({scan_pos[CNT_W-1:BIT_W], BIT_W'(j)} < n_eff)) begin
        sc_found = 1'b1;
        sc_bit   = BIT_W'(j);
      end
    end
  end

  function automatic res_t mk(input logic [2:0] st, input logic [ADDR_W-1:0] a,
                              input logic [CNT_W-1:0] ix, input logic u);
    res_t r;
    r.status         = st;
    r.result_address = a;
    r.result_index   = ix;
    r.in_use         = u;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      stack_top <= '0;
      row_valid <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op      <= cmd.opcode;
            cv_addr <= cmd.object_address;
            full    <= (stack_top >= n_eff);
            case (cmd.opcode)
              OP_ALLOC: begin
                if (stack_top == '0) begin
                  done   <= 1'b1;
                  result <= mk(ST_EMPTY, '0, n_eff, 1'b0);
                end else begin
                  stack_top <= stack_top - CNT_W'(1);
                  state     <= S_A_RD;
                end
              end
              OP_FREE, OP_TEST, OP_NEXT: begin
                if (cmd.opcode == OP_NEXT && !tracking_enable) begin
                  done   <= 1'b1;
                  result <= mk(ST_NONE, '0, n_eff, 1'b0);
                end else begin
                  state <= S_CV_MUL;
                end
              end
              OP_FIRST: begin
                if (!tracking_enable) begin
                  done   <= 1'b1;
                  result <= mk(ST_NONE, '0, n_eff, 1'b0);
                end else begin
                  scan_pos <= '0;
                  state    <= S_SC_RD;
                end
              end
              OP_REINIT: begin
                ri_i      <= '0;
                ri_addr   <= pool_base;
                row_valid <= '0;
                state     <= S_RI_LOOP;
              end
              default: ;
            endcase
          end
        end
        S_A_RD: begin
          cv_addr <= stk_rdata;
          state   <= S_CV_MUL;
        end
        S_CV_MUL: begin
          span  <= SPAN_W'(object_stride) * SPAN_W'(n_eff);
          off   <= cv_addr - pool_base;
          below <= (cv_addr < pool_base);
          state <= S_CV_CHK;
        end
        S_CV_CHK: begin
          q    <= '0;
          bitn <= 4'd9;
          rem  <= off[SPAN_W-1:0];
          if (below || off_big) begin
            cv_ok <= 1'b0;
            state <= S_CV_END;
          end else begin
            cv_ok <= 1'b1;
            state <= S_CV_DIV;
          end
        end
        S_CV_DIV: begin
          if (rem >= trial) begin
            rem     <= rem - trial;
            q[bitn] <= 1'b1;
          end
          if (bitn == 4'd0) begin
            state <= S_CV_END;
          end else begin
            bitn <= bitn - 4'd1;
          end
        end
        S_CV_END: begin
          state <= S_IDLE;
          case (op)
            OP_ALLOC: begin
              if (!tracking_enable) begin
                done   <= 1'b1;
                result <= mk(ST_OK, cv_addr, idx_out, 1'b0);
              end else if (!cv_ok) begin
                done   <= 1'b1;
                result <= mk(ST_DBL_ALOC, '0, n_eff, 1'b0);
              end else begin
                state <= S_MAP_RD;
              end
            end
            OP_FREE: begin
              if (full) begin
                done   <= 1'b1;
                result <= mk(ST_FULL, '0, idx_out, 1'b0);
              end else if (!tracking_enable) begin
                stack_top <= stack_top + CNT_W'(1);
                done      <= 1'b1;
                result    <= mk(ST_OK, '0, idx_out, 1'b0);
              end else if (!cv_ok) begin
                done   <= 1'b1;
                result <= mk(ST_BAD_ADDR, '0, n_eff, 1'b0);
              end else begin
                state <= S_MAP_RD;
              end
            end
            OP_TEST: begin
              if (!cv_ok) begin
                done   <= 1'b1;
                result <= mk(ST_BAD_ADDR, '0, n_eff, 1'b0);
              end else if (!tracking_enable) begin
                done   <= 1'b1;
                result <= mk(ST_OK, '0, idx_out, 1'b0);
              end else begin
                state <= S_MAP_RD;
              end
            end
            default: begin
              if (!cv_ok) begin
                done   <= 1'b1;
                result <= mk(ST_BAD_ADDR, '0, n_eff, 1'b0);
              end else begin
                scan_pos <= {1'b0, q} + CNT_W'(1);
                state    <= S_SC_RD;
              end
            end
          endcase
        end
        S_MAP_RD: begin
          state <= S_IDLE;
          done  <= 1'b1;
          case (op)
            OP_ALLOC: begin
              if (obj_bit) begin
                result <= mk(ST_DBL_ALOC, '0, idx_out, 1'b0);
              end else begin
                row_valid[q[IDX_W-1:BIT_W]] <= 1'b1;
                result <= mk(ST_OK, cv_addr, idx_out, 1'b0);
              end
            end
            OP_FREE: begin
              if (!obj_bit) begin
                result <= mk(ST_DBL_FREE, '0, idx_out, 1'b0);
              end else begin
                row_valid[q[IDX_W-1:BIT_W]] <= 1'b1;
                stack_top <= stack_top + CNT_W'(1);
                result    <= mk(ST_OK, '0, idx_out, 1'b0);
              end
            end
            default: result <= mk(ST_OK, '0, idx_out, obj_bit);
          endcase
        end
        S_SC_RD: begin
          if (scan_pos >= n_eff) begin
            done   <= 1'b1;
            result <= mk(ST_NONE, '0, n_eff, 1'b0);
            state  <= S_IDLE;
          end else begin
            state <= S_SC_CHK;
          end
        end
        S_SC_CHK: begin
          if (sc_found) begin
            q     <= {scan_pos[IDX_W-1:BIT_W], sc_bit};
            state <= S_IA_MUL;
          end else begin
            scan_pos <= {scan_pos[CNT_W-1:BIT_W] + (CNT_W-BIT_W)'(1), BIT_W'(0)};
            state    <= S_SC_RD;
          end
        end
        S_IA_MUL: begin
          prod  <= object_stride * q;
          state <= S_IA_ADD;
        end
        S_IA_ADD: begin
          done   <= 1'b1;
          result <= mk(ST_OK, pool_base + ADDR_W'(prod), {1'b0, q}, 1'b0);
          state  <= S_IDLE;
        end
        S_RI_LOOP: begin
          if (ri_i >= n_eff) begin
            stack_top <= n_eff;
            done      <= 1'b1;
            result    <= mk(ST_OK, '0, n_eff, 1'b0);
            state     <= S_IDLE;
          end else begin
            ri_i    <= ri_i + CNT_W'(1);
            ri_addr <= ri_addr + ADDR_W'(object_stride);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while still busy");
  a_top_cap: assert property (@(posedge clk) disable iff (rst)
    stack_top <= CNT_W'(MAX_OBJECTS))
    else $error("stack top beyond capacity");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.opcode == OP_ALLOC && stack_top == '0)
    |=> (done && result.status == ST_EMPTY))
    else $error("alloc on empty stack not reported");
`endif
endmodule
`default_nettype wire

/* rtl/ops_ram.sv */
`default_nettype none
module ops_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none

import ops_pkg::*;

class pool_scoreboard;
  logic [ADDR_W-1:0] base;
  logic [STRIDE_W-1:0] stride;
  logic [CNT_W-1:0] count;
  bit track;
  logic [ADDR_W-1:0] free_mem [MAX_OBJECTS];
  int top;
  bit out_map [MAX_OBJECTS];
  res_t expected_q [$];
  int errors;

  function new();
    base = '0;
    stride = 1;
    count = '0;
    track = 0;
    top = 0;
    errors = 0;
    foreach (out_map[i]) out_map[i] = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [ADDR_W-1:0] val);
    case (idx)
      REG_BASE: base = val;
      REG_STRIDE: stride = val[STRIDE_W-1:0];
      REG_COUNT: count = val[CNT_W-1:0];
      REG_TRACK: track = val[0];
      default: ;
    endcase
  endfunction

  function int eff();
    return (count > MAX_OBJECTS) ? MAX_OBJECTS : int'(count);
  endfunction

  // -1 when the address is outside the pool
  function int obj_index(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] off, span;
    if (stride == 0 || a < base) return -1;
    off = a - base;
    span = ADDR_W'(stride) * ADDR_W'(eff());
    if (off >= span) return -1;
    return int'(off / ADDR_W'(stride));
  endfunction

  function logic [ADDR_W-1:0] obj_addr(int i);
    return base + ADDR_W'(stride) * ADDR_W'(i);
  endfunction

  function int scan(int from);
    for (int i = from; i < eff(); i++) if (out_map[i]) return i;
    return -1;
  endfunction

  function res_t mk(logic [2:0] st, logic [ADDR_W-1:0] a, int i, bit u);
    res_t r;
    r.status = st;
    r.result_address = a;
    r.result_index = CNT_W'((i < 0) ? eff() : i);
    r.in_use = u;
    return r;
  endfunction

  function void note_cmd(cmd_t c);
    int i, j;
    logic [ADDR_W-1:0] e;
    res_t r;
    i = obj_index(c.object_address);
    case (c.opcode)
      OP_ALLOC: begin
        if (top == 0) begin
          r = mk(ST_EMPTY, '0, -1, 0);
        end else begin
          top--;
          e = free_mem[top];
          j = obj_index(e);
          if (track && (j < 0 || out_map[j])) begin
            r = mk(ST_DBL_ALOC, '0, j, 0);
          end else begin
            if (track) out_map[j] = 1;
            r = mk(ST_OK, e, j, 0);
          end
        end
      end
      OP_FREE: begin
        if (top >= eff()) r = mk(ST_FULL, '0, i, 0);
        else if (track && i < 0) r = mk(ST_BAD_ADDR, '0, i, 0);
        else if (track && !out_map[i]) r = mk(ST_DBL_FREE, '0, i, 0);
        else begin
          if (track) out_map[i] = 0;
          free_mem[top] = c.object_address;
          top++;
          r = mk(ST_OK, '0, i, 0);
        end
      end
      OP_TEST: begin
        if (i < 0) r = mk(ST_BAD_ADDR, '0, i, 0);
        else r = mk(ST_OK, '0, i, track & out_map[i]);
      end
      OP_FIRST, OP_NEXT: begin
        if (!track) r = mk(ST_NONE, '0, -1, 0);
        else if (c.opcode == OP_NEXT && i < 0) r = mk(ST_BAD_ADDR, '0, i, 0);
        else begin
          j = scan((c.opcode == OP_FIRST) ? 0 : i + 1);
          if (j < 0) r = mk(ST_NONE, '0, j, 0);
          else r = mk(ST_OK, obj_addr(j), j, 0);
        end
      end
      OP_REINIT: begin
        for (int k = 0; k < eff(); k++) free_mem[k] = obj_addr(k);
        top = eff();
        foreach (out_map[k]) out_map[k] = 0;
        r = mk(ST_OK, '0, -1, 0);
      end
      default: return;
    endcase
    expected_q.push_back(r);
  endfunction

  function void check_res(res_t got);
    res_t w;
    if (expected_q.size() == 0) begin
      $error("unexpected result beat %p", got);
      errors++;
      return;
    end
    w = expected_q.pop_front();
    if (got.status !== w.status) begin
      $error("status exp %0d got %0d", w.status, got.status);
      errors++;
    end
    if (got.result_address !== w.result_address) begin
      $error("result_address exp %h got %h", w.result_address, got.result_address);
      errors++;
    end
    if (got.result_index !== w.result_index) begin
      $error("result_index exp %0d got %0d", w.result_index, got.result_index);
      errors++;
    end
    if (got.in_use !== w.in_use) begin
      $error("in_use exp %0d got %0d", w.in_use, got.in_use);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int LIMIT = 10000000;
  localparam int DRAIN = 40;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  cmd_t cmd = '0;
  logic busy, done;
  res_t result;
  logic wr_en = 0;
  logic [1:0] wr_index = '0;
  logic [ADDR_W-1:0] wr_data = '0;

  pool_scoreboard sb = new();
  int cycles = 0;
  bit idle_on = 1;

  object_pool_free_stack i_dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_res(result);
      if (start && !busy) sb.note_cmd(cmd);
    end
  end

  function cmd_t mk_cmd(logic [2:0] op, logic [ADDR_W-1:0] a);
    cmd_t c;
    c.opcode = op;
    c.object_address = a;
    return c;
  endfunction

  task send(cmd_t c);
    start <= 1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task wait_idle();
    start <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [ADDR_W-1:0] val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    wr_en <= 0;
  endtask

  function logic [ADDR_W-1:0] pick_addr();
    int r;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 9);
    a = sb.obj_addr($urandom_range(0, sb.eff()));
    if (r == 6 && sb.stride > 0) a = a + $urandom_range(0, int'(sb.stride) - 1);
    else if (r == 7) a = {$urandom, $urandom};
    else if (r == 8) a = sb.base - 1;
    return a;
  endfunction

  task random_items(int n);
    int r;
    logic [2:0] op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_ALLOC;
      else if (r < 60) op = OP_FREE;
      else if (r < 72) op = OP_TEST;
      else if (r < 80) op = OP_FIRST;
      else if (r < 92) op = OP_NEXT;
      else if (r < 95) op = OP_REINIT;
      else op = 3'($urandom_range(6, 7));
      send(mk_cmd(op, pick_addr()));
    end
  endtask

  task phase(logic [ADDR_W-1:0] b, logic [STRIDE_W-1:0] s, logic [CNT_W-1:0] c,
             bit t, int n);
    wait_idle();
    write_reg(REG_BASE, b);
    write_reg(REG_STRIDE, ADDR_W'(s));
    write_reg(REG_COUNT, ADDR_W'(c));
    write_reg(REG_TRACK, ADDR_W'(t));
    send(mk_cmd(OP_REINIT, '0));
    random_items(n);
  endtask

  initial begin
    logic [ADDR_W-1:0] b;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset config: empty stack, zero capacity
    send(mk_cmd(OP_ALLOC, '0));
    send(mk_cmd(OP_FREE, '1));
    send(mk_cmd(OP_FIRST, '0));
    b = 64'd1000;
    wait_idle();
    write_reg(REG_BASE, b);
    write_reg(REG_STRIDE, 8);
    write_reg(REG_COUNT, 8);
    write_reg(REG_TRACK, 1);
    send(mk_cmd(OP_REINIT, '0));
    send(mk_cmd(OP_ALLOC, '0));
    send(mk_cmd(OP_ALLOC, '0));
    send(mk_cmd(OP_TEST, b + 56));
    send(mk_cmd(OP_TEST, b + 1));
    send(mk_cmd(OP_TEST, b - 1));
    send(mk_cmd(OP_FIRST, '0));
    send(mk_cmd(OP_NEXT, b));
    send(mk_cmd(OP_NEXT, b + 56));
    send(mk_cmd(OP_NEXT, b + 64));
    send(mk_cmd(OP_FREE, b + 56));
    send(mk_cmd(OP_FREE, b + 56));
    send(mk_cmd(OP_FREE, '1));
    send(mk_cmd(3'd6, '0));
    send(mk_cmd(3'd7, '1));
    send(mk_cmd(OP_FREE, b + 48));
    send(mk_cmd(OP_FREE, b + 8));
    // tracking off: unchecked pushes, searches report nothing
    wait_idle();
    write_reg(REG_TRACK, 0);
    send(mk_cmd(OP_ALLOC, '0));
    send(mk_cmd(OP_FREE, '0));
    send(mk_cmd(OP_FIRST, '0));
    // popping the stray address with tracking on flags a double alloc
    wait_idle();
    write_reg(REG_TRACK, 1);
    send(mk_cmd(OP_ALLOC, '0));
    send(mk_cmd(OP_ALLOC, '0));

    phase(64'd0, 1, 8, 1, 160);
    phase({$urandom, $urandom}, 25'($urandom_range(1, 5000)), 16, 1, 160);
    phase(64'hFFFF_FFFF_FFFF_FF00, 24, 32, 1, 160);
    phase({$urandom, $urandom}, 25'd16777216, 5, 0, 150);
    phase({$urandom, $urandom}, 7, 0, 1, 60);
    phase(64'd4096, 1, 1024, 1, 80);
    phase({$urandom, $urandom}, 3, 11'd2047, 0, 120);
    // flip tracking without reinit: bitmap and stack keep their contents
    wait_idle();
    write_reg(REG_TRACK, 1);
    random_items(120);
    phase(64'd500, 0, 6, 1, 40);
    phase('1, 2, 4, 1, 100);
    phase(64'd256, 4, 6, 1, 30);
    wait_idle();
    write_reg(REG_COUNT, 3);
    random_items(60);
    idle_on = 0;
    phase({$urandom, $urandom}, 25'($urandom_range(1, 64)), 10, 1, 150);

    wait_idle();
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
